@@ src/kto_pkg.sv @@
// ----------------------------------------------------------------------------
// kto_pkg
// Shared constants and types for the keyed slot table.
// ----------------------------------------------------------------------------
package kto_pkg;

    localparam int SLOTS_DEF     = 32;
    localparam int KEY_BYTES_DEF = 32;
    localparam int KEY_W         = 256;
    localparam int STAMP_W       = 32;
    localparam int FUNC_W        = 3;
    localparam int LEN_W         = 6;
    localparam int ORD_W         = 8;
    localparam int SLOT_OUT_W    = 5;
    localparam int COUNT_OUT_W   = 6;

    localparam logic [FUNC_W-1:0] FN_FIND   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_UPSERT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_NTH    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_COUNT  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd5;
    // Unassigned codes: change nothing, answer ok 0.
    localparam logic [FUNC_W-1:0] FN_SPARE6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE7 = 3'd7;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_MATCH = 2'd1;
    localparam logic [1:0] ACT_FREE  = 2'd2;
    localparam logic [1:0] ACT_EVICT = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Per-cell write or clear command from the controller.
    typedef struct packed {
        logic wr;
        logic clr;
    } t_cell_cmd;

endpackage

@@ src/keyed_table_oldest_replace.sv @@
// ----------------------------------------------------------------------------
// keyed_table_oldest_replace
// Slotted key table with prefix find and remove, upsert with oldest-stamp
// eviction, ordinal lookup, count and clear.
// Usage:
//   Slave channel (s_axis_*) takes one command transaction: func in tuser,
//   key words, prefix_len, stamp and ordinal packed in tdata. Master channel
//   (m_axis_*) returns one result transaction per command.
//   A command passes through a scan, a commit that writes or clears the
//   chosen cell, and the result handshake; no new command is taken before
//   the result transaction completes. The scan visits one cell per cycle.
//   The search key moves one cell down the row per cycle, so each cell sees
//   it exactly when the sequencer visits that cell and compares it there.
//   Reset clears all used flags, the count and the dirty mark; stored keys
//   and stamps are left as they are. tready stays low during reset.
//   When the receiver stalls, the result is held and no new command is
//   taken until the result transaction completes.
// ----------------------------------------------------------------------------
module keyed_table_oldest_replace #(
    parameter int SLOTS     = kto_pkg::SLOTS_DEF,
    parameter int KEY_BYTES = kto_pkg::KEY_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: key_word0, key_word1, key_word2, key_word3, prefix_len, stamp,
    // ordinal (from bit 0 up), zero pad to 304 bits
    input  logic [303:0] s_axis_tdata,
    // tuser: func
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: ok, slot, action, count, dirty (from bit 0 up), zero pad
    output logic [15:0]  m_axis_tdata
);
    localparam int SW = $clog2(SLOTS);

    logic [kto_pkg::KEY_W-1:0] in_key;
    logic [kto_pkg::LEN_W-1:0] in_len;
    logic start;

    assign in_key = s_axis_tdata[255:0];
    assign in_len = s_axis_tdata[261:256];

    // Hold the command key and masks for the whole scan.
    logic [kto_pkg::KEY_W-1:0]   r_key, r_mask, r_fmask;
    logic [kto_pkg::STAMP_W-1:0] r_stamp;
    logic                        busy, done;

    assign s_axis_tready = i_rst_n && !busy;
    assign start = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_key   <= in_key;
            r_stamp <= s_axis_tdata[293:262];
            for (int b = 0; b < kto_pkg::KEY_W / 8; b++) begin
                r_mask[b*8 +: 8]  <= (b < int'(in_len) && b < KEY_BYTES) ? 8'hFF : 8'h00;
                r_fmask[b*8 +: 8] <= (b < KEY_BYTES) ? 8'hFF : 8'h00;
            end
        end
    end

    logic len_ok;
    assign len_ok = (in_len != '0) && (int'(in_len) <= KEY_BYTES);

    // Row of cells; the key passes from each cell to the next.
    logic [kto_pkg::KEY_W-1:0]   chain [SLOTS+1];
    logic [SLOTS-1:0]            used, pm, fm;
    logic [kto_pkg::STAMP_W-1:0] stamps [SLOTS];
    kto_pkg::t_cell_cmd          cmd [SLOTS];

    assign chain[0] = r_key;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        kto_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (cmd[g]),
            .i_wkey   (r_key),
            .i_wstamp (r_stamp),
            .i_key    (chain[g]),
            .i_mask   (r_mask),
            .i_fmask  (r_fmask),
            .o_key    (chain[g+1]),
            .o_used   (used[g]),
            .o_stamp  (stamps[g]),
            .o_pmatch (pm[g]),
            .o_fmatch (fm[g])
        );
    end

    logic          ok, dirty;
    logic [SW-1:0] slot;
    logic [1:0]    action;
    logic [SW:0]   count;

    kto_ctrl #(.SLOTS(SLOTS), .SW(SW)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_func   (s_axis_tuser),
        .i_ord    (s_axis_tdata[301:294]),
        .i_len_ok (len_ok),
        .i_take   (m_axis_tvalid && m_axis_tready),
        .i_used   (used),
        .i_pm     (pm),
        .i_fm     (fm),
        .i_stamp  (stamps),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (done),
        .o_ok     (ok),
        .o_slot   (slot),
        .o_action (action),
        .o_count  (count),
        .o_dirty  (dirty)
    );

    logic [kto_pkg::SLOT_OUT_W-1:0]  slot_o;
    logic [kto_pkg::COUNT_OUT_W-1:0] count_o;
    assign slot_o  = kto_pkg::SLOT_OUT_W'({{8{1'b0}}, slot});
    assign count_o = kto_pkg::COUNT_OUT_W'({{8{1'b0}}, count});

    assign m_axis_tvalid = done;
    assign m_axis_tdata  = {1'b0, dirty, count_o, action, slot_o, ok};

    // Never accept a command while a result is outstanding.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("accept during result");
    // Count stays within the table size.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= (SW+1)'(SLOTS)) else $error("count overflow");
    // When a result is shown, the number of used flags matches the count.
    a_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($countones(used) == int'(count)))
        else $error("count mismatch");
endmodule

@@ src/kto_cell.sv @@
// ----------------------------------------------------------------------------
// kto_cell
// One table slot: key, stamp and used flag; compares against the key that
// passes through the chain and hands that key on to its neighbor.
// ----------------------------------------------------------------------------
module kto_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kto_pkg::t_cell_cmd            i_cmd,
    input  logic [kto_pkg::KEY_W-1:0]     i_wkey,
    input  logic [kto_pkg::STAMP_W-1:0]   i_wstamp,
    input  logic [kto_pkg::KEY_W-1:0]     i_key,
    input  logic [kto_pkg::KEY_W-1:0]     i_mask,
    input  logic [kto_pkg::KEY_W-1:0]     i_fmask,
    output logic [kto_pkg::KEY_W-1:0]     o_key,
    output logic                          o_used,
    output logic [kto_pkg::STAMP_W-1:0]   o_stamp,
    output logic                          o_pmatch,
    output logic                          o_fmatch
);
    logic [kto_pkg::KEY_W-1:0]   r_key;
    logic [kto_pkg::STAMP_W-1:0] r_stamp;
    logic                        r_used;
    logic [kto_pkg::KEY_W-1:0]   r_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_cmd.wr) begin
            r_used <= 1'b1;
        end else if (i_cmd.clr) begin
            r_used <= 1'b0;
        end
        if (i_cmd.wr) begin
            r_key   <= i_wkey;
            r_stamp <= i_wstamp;
        end else if (i_cmd.clr) begin
            r_key   <= '0;
            r_stamp <= '0;
        end
        // Advance the search key one cell per cycle.
        r_pass <= i_key;
    end

    assign o_key    = r_pass;
    assign o_used   = r_used;
    assign o_stamp  = r_stamp;
    assign o_pmatch = r_used && (((r_key ^ i_key) & i_mask) == '0);
    assign o_fmatch = r_used && (((r_key ^ i_key) & i_fmask) == '0);
endmodule

@@ src/kto_ctrl.sv @@
// ----------------------------------------------------------------------------
// kto_ctrl
// Sequencer that walks the cell row one slot per cycle, picks the result and
// commands the write or clear of the chosen cell.
module kto_ctrl #(
    parameter int SLOTS = kto_pkg::SLOTS_DEF,
    parameter int SW    = $clog2(SLOTS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [kto_pkg::FUNC_W-1:0]    i_func,
    input  logic [kto_pkg::ORD_W-1:0]     i_ord,
    input  logic                          i_len_ok,
    input  logic                          i_take,
    input  logic [SLOTS-1:0]              i_used,
    input  logic [SLOTS-1:0]              i_pm,
    input  logic [SLOTS-1:0]              i_fm,
    input  logic [kto_pkg::STAMP_W-1:0]   i_stamp [SLOTS],
    output kto_pkg::t_cell_cmd            o_cmd [SLOTS],
    output logic                          o_busy,
    output logic                          o_done,
    output logic                          o_ok,
    output logic [SW-1:0]                 o_slot,
    output logic [1:0]                    o_action,
    output logic [SW:0]                   o_count,
    output logic                          o_dirty
);
    kto_pkg::t_state r_state, n_state;
    logic [SW:0]   r_idx;
    logic [kto_pkg::FUNC_W-1:0] r_func;
    logic [kto_pkg::ORD_W-1:0]  r_ord;
    logic          r_lok;
    logic          r_ph, r_fh, r_freeh, r_nh;
    logic [SW-1:0] r_ps, r_fs, r_frees, r_old, r_ns;
    logic [kto_pkg::STAMP_W-1:0] r_oldt;
    logic [kto_pkg::ORD_W:0] r_seen;
    logic [SW:0]   r_count;
    logic          r_dirty, r_ok;
    logic [SW-1:0] r_slot;
    logic [1:0]    r_act;
    logic [SW-1:0] cur;
    logic          scan_end;

    assign cur      = r_idx[SW-1:0];
    assign scan_end = (r_idx == (SW+1)'(SLOTS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kto_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kto_pkg::ST_IDLE: if (i_start) n_state = kto_pkg::ST_SCAN;
            kto_pkg::ST_SCAN: if (scan_end) n_state = kto_pkg::ST_DONE;
            kto_pkg::ST_DONE: if (i_take) n_state = kto_pkg::ST_IDLE;
            default:          n_state = kto_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_dirty <= 1'b0;
        end else if (r_state == kto_pkg::ST_SCAN && scan_end) begin
            priority case (r_func)
                kto_pkg::FN_UPSERT: begin
                    r_dirty <= 1'b1;
                    if (!(r_fh || (i_fm[cur]))) begin
                        if (r_freeh || !i_used[cur]) r_count <= r_count + 1'b1;
                    end
                end
                kto_pkg::FN_REMOVE: begin
                    if (r_lok && (r_ph || i_pm[cur])) begin
                        r_dirty <= 1'b1;
                        r_count <= r_count - 1'b1;
                    end
                end
                kto_pkg::FN_CLEAR: r_dirty <= 1'b0;
                default: ;
            endcase
        end
    end

    // Per-slot scan accumulators; results latch on the last slot.
    always_ff @(posedge i_clk) begin
        logic ph, fh, freeh, nh;
        logic [SW-1:0] ps, fs, frees, old, ns, sl;
        logic [kto_pkg::STAMP_W-1:0] oldt;
        logic ok;
        logic [1:0] act;
        ph = r_ph; fh = r_fh; freeh = r_freeh; nh = r_nh;
        ps = r_ps; fs = r_fs; frees = r_frees; old = r_old; ns = r_ns;
        oldt = r_oldt;
        if (r_state == kto_pkg::ST_IDLE && i_start) begin
            r_idx   <= '0;
            r_func  <= i_func;
            r_ord   <= i_ord;
            r_lok   <= i_len_ok;
            r_ph    <= 1'b0; r_fh <= 1'b0; r_freeh <= 1'b0; r_nh <= 1'b0;
            r_ps    <= '0; r_fs <= '0; r_frees <= '0; r_old <= '0; r_ns <= '0;
            r_oldt  <= '1;
            r_seen  <= '0;
        end else if (r_state == kto_pkg::ST_SCAN) begin
            if (!ph && i_pm[cur]) begin ph = 1'b1; ps = cur; end
            if (!fh && i_fm[cur]) begin fh = 1'b1; fs = cur; end
            if (!freeh) begin
                if (!i_used[cur]) begin
                    freeh = 1'b1; frees = cur;
                end else if (i_stamp[cur] < oldt) begin
                    oldt = i_stamp[cur]; old = cur;
                end
            end
            if (!nh && i_used[cur]) begin
                if (r_seen == {1'b0, r_ord}) begin nh = 1'b1; ns = cur; end
                r_seen <= r_seen + 1'b1;
            end
            r_ph <= ph; r_fh <= fh; r_freeh <= freeh; r_nh <= nh;
            r_ps <= ps; r_fs <= fs; r_frees <= frees; r_old <= old; r_ns <= ns;
            r_oldt <= oldt;
            r_idx <= r_idx + 1'b1;
            if (scan_end) begin
                ok = 1'b0; sl = '0; act = kto_pkg::ACT_NONE;
                priority case (r_func)
                    kto_pkg::FN_FIND, kto_pkg::FN_REMOVE: begin
                        if (r_lok && ph) begin ok = 1'b1; sl = ps; end
                    end
                    kto_pkg::FN_UPSERT: begin
                        ok = 1'b1;
                        if (fh) begin sl = fs; act = kto_pkg::ACT_MATCH; end
                        else if (freeh) begin sl = frees; act = kto_pkg::ACT_FREE; end
                        else begin sl = old; act = kto_pkg::ACT_EVICT; end
                    end
                    kto_pkg::FN_NTH: begin
                        if (nh) begin ok = 1'b1; sl = ns; end
                    end
                    kto_pkg::FN_COUNT, kto_pkg::FN_CLEAR: ok = 1'b1;
                    default: ;
                endcase
                r_ok <= ok; r_slot <= sl; r_act <= act;
            end
        end
    end

    // Write or clear the chosen cell once the scan ends (combinational on
    // the final accumulators would be deep, so commit in the next cycle).
    logic r_commit;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_commit <= 1'b0;
        end else begin
            r_commit <= (r_state == kto_pkg::ST_SCAN) && scan_end;
        end
    end

    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            o_cmd[s].wr  = r_commit && r_func == kto_pkg::FN_UPSERT && r_slot == SW'(s);
            o_cmd[s].clr = r_commit && r_func == kto_pkg::FN_REMOVE && r_ok
                           && r_slot == SW'(s);
        end
    end

    assign o_busy   = (r_state != kto_pkg::ST_IDLE);
    assign o_done   = (r_state == kto_pkg::ST_DONE) && !r_commit;
    assign o_ok     = r_ok;
    assign o_slot   = r_slot;
    assign o_action = r_act;
    assign o_count  = r_count;
    assign o_dirty  = r_dirty;
endmodule

@@ tb/kto_checker.sv @@
// ----------------------------------------------------------------------------
// kto_checker
// Watches both stream channels of the keyed slot table. Keeps a shadow copy
// of the table, works out the result of every accepted command and compares
// each returned result with the oldest outstanding one.
// ----------------------------------------------------------------------------
module kto_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cmd_valid,
    input  logic         i_cmd_ready,
    input  logic [303:0] i_cmd_data,
    input  logic [2:0]   i_cmd_func,
    input  logic         i_res_valid,
    input  logic         i_res_ready,
    input  logic [15:0]  i_res_data,
    output int           o_errors,
    output int           o_pending
);

    // Fields from the top bit down, so ok lands in bit 0.
    typedef struct packed {
        logic       dirty;
        logic [5:0] count;
        logic [1:0] action;
        logic [4:0] slot;
        logic       ok;
    } t_outcome;

    logic [kto_pkg::KEY_W-1:0]   shadow_key   [kto_pkg::SLOTS_DEF];
    logic [kto_pkg::STAMP_W-1:0] shadow_stamp [kto_pkg::SLOTS_DEF];
    logic [kto_pkg::SLOTS_DEF-1:0] shadow_used;
    logic               shadow_dirty;
    t_outcome           outcomes_due [$];

    function automatic int find_slot(logic [kto_pkg::KEY_W-1:0] key, int len);
        bit eq;
        if (len == 0 || len > kto_pkg::KEY_BYTES_DEF) return -1;
        for (int s = 0; s < kto_pkg::SLOTS_DEF; s++) begin
            if (shadow_used[s]) begin
                eq = 1;
                for (int i = 0; i < len; i++)
                    if (shadow_key[s][8*i +: 8] != key[8*i +: 8]) eq = 0;
                if (eq) return s;
            end
        end
        return -1;
    endfunction

    // Apply one command to the shadow table and return its outcome.
    function automatic t_outcome apply_command(logic [2:0] fn, logic [303:0] d);
        t_outcome r;
        logic [kto_pkg::KEY_W-1:0] key;
        int len, ord, hit, seen, oldest;
        logic [kto_pkg::STAMP_W-1:0] oldest_t;
        bit placed;
        key = d[255:0];
        len = int'(d[261:256]);
        ord = int'(d[301:294]);
        r = '0;
        case (fn)
            kto_pkg::FN_FIND: begin
                hit = find_slot(key, len);
                if (hit >= 0) begin
                    r.ok = 1;
                    r.slot = 5'(hit);
                end
            end
            kto_pkg::FN_UPSERT: begin
                hit = find_slot(key, kto_pkg::KEY_BYTES_DEF);
                if (hit >= 0) begin
                    r.action = kto_pkg::ACT_MATCH;
                end else begin
                    placed = 0;
                    oldest = 0;
                    oldest_t = '1;
                    for (int s = 0; s < kto_pkg::SLOTS_DEF && !placed; s++) begin
                        if (!shadow_used[s]) begin
                            hit = s;
                            placed = 1;
                        end else if (shadow_stamp[s] < oldest_t) begin
                            oldest_t = shadow_stamp[s];
                            oldest = s;
                        end
                    end
                    r.action = placed ? kto_pkg::ACT_FREE : kto_pkg::ACT_EVICT;
                    if (!placed) hit = oldest;
                end
                shadow_key[hit] = key;
                shadow_stamp[hit] = d[293:262];
                shadow_used[hit] = 1;
                shadow_dirty = 1;
                r.ok = 1;
                r.slot = 5'(hit);
            end
            kto_pkg::FN_REMOVE: begin
                hit = find_slot(key, len);
                if (hit >= 0) begin
                    shadow_used[hit] = 0;
                    shadow_dirty = 1;
                    r.ok = 1;
                    r.slot = 5'(hit);
                end
            end
            kto_pkg::FN_NTH: begin
                seen = 0;
                for (int s = 0; s < kto_pkg::SLOTS_DEF && !r.ok; s++) begin
                    if (shadow_used[s]) begin
                        if (seen == ord) begin
                            r.ok = 1;
                            r.slot = 5'(s);
                        end
                        seen++;
                    end
                end
            end
            kto_pkg::FN_COUNT: r.ok = 1;
            kto_pkg::FN_CLEAR: begin
                shadow_dirty = 0;
                r.ok = 1;
            end
            default: ;
        endcase
        r.count = 6'($countones(shadow_used));
        r.dirty = shadow_dirty;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want, got;
        if (!i_rst_n) begin
            shadow_used = '0;
            shadow_dirty = 0;
            o_errors <= 0;
            outcomes_due.delete();
            o_pending <= 0;
        end else begin
            if (i_cmd_valid && i_cmd_ready)
                outcomes_due.push_back(apply_command(i_cmd_func, i_cmd_data));
            if (i_res_valid && i_res_ready) begin
                got = i_res_data[14:0];
                if (outcomes_due.size() == 0) begin
                    $display("%0t: result with nothing outstanding, got %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = outcomes_due.pop_front();
                    if (got.ok != want.ok || got.slot != want.slot ||
                        got.action != want.action || got.count != want.count ||
                        got.dirty != want.dirty) begin
                        $display("%0t: mismatch expected ok=%0d slot=%0d act=%0d cnt=%0d dirty=%0d",
                                 $time, want.ok, want.slot, want.action, want.count, want.dirty);
                        $display("%0t:          actual   ok=%0d slot=%0d act=%0d cnt=%0d dirty=%0d",
                                 $time, got.ok, got.slot, got.action, got.count, got.dirty);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= outcomes_due.size();
        end
    end

endmodule

@@ tb/tb_keyed_table_oldest_replace.sv @@
// ----------------------------------------------------------------------------
// tb_keyed_table_oldest_replace
// Drives directed and random table commands through the slave channel,
// stalls the result channel at random, and lets kto_checker judge results.
// ----------------------------------------------------------------------------
module tb_keyed_table_oldest_replace;

    localparam int CYCLE_LIMIT = 600000;
    localparam int POOL_N      = 40;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // tdata: key_word0..3, prefix_len, stamp, ordinal (from bit 0 up), zero pad
    logic [303:0] s_axis_tdata;
    // tuser: func
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // tdata: ok, slot, action, count, dirty (from bit 0 up), zero pad
    logic [15:0]  m_axis_tdata;
    int           errors;
    int           pending;
    int           cycles = 0;
    int           send_gap_max;
    logic [kto_pkg::KEY_W-1:0] key_pool [POOL_N];

    keyed_table_oldest_replace dut (.*);

    kto_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(s_axis_tvalid), .i_cmd_ready(s_axis_tready),
        .i_cmd_data(s_axis_tdata), .i_cmd_func(s_axis_tuser),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .i_res_data(m_axis_tdata), .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 0;
        #10;
        i_clk = 1;
        #10;
    end

    // Abort on a hang.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[keyed_table_oldest_replace] ERROR");
            $finish;
        end
    end

    // Result side: draw a stall per transaction; some stretches never stall.
    initial begin
        int stall, quiet;
        bit seen;
        m_axis_tready = 0;
        quiet = 0;
        @(posedge i_clk iff i_rst_n);
        m_axis_tready <= 1;
        forever begin
            do begin
                @(negedge i_clk);
                seen = m_axis_tvalid && m_axis_tready;
                @(posedge i_clk);
            end while (!seen);
            if (quiet > 0) quiet--;
            else if ($urandom_range(0, 40) == 0) quiet = $urandom_range(20, 60);
            stall = quiet > 0 ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_axis_tready <= 0;
                repeat (stall) @(posedge i_clk);
                m_axis_tready <= 1;
            end
        end
    end

    // Hold one command until the table takes it, then drop valid.
    task automatic send_cmd(logic [2:0] fn, logic [kto_pkg::KEY_W-1:0] key, int len,
                            logic [31:0] stamp, int ord);
        bit seen;
        int gap;
        gap = $urandom_range(0, send_gap_max);
        repeat (gap) @(posedge i_clk);
        s_axis_tvalid <= 1;
        s_axis_tuser <= fn;
        s_axis_tdata <= {2'b0, ord[7:0], stamp, len[5:0], key};
        do begin
            @(negedge i_clk);
            seen = s_axis_tready;
            @(posedge i_clk);
        end while (!seen);
        s_axis_tvalid <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [kto_pkg::KEY_W-1:0] rand_key();
        logic [kto_pkg::KEY_W-1:0] k;
        for (int i = 0; i < 8; i++) k[32*i +: 32] = $urandom;
        return k;
    endfunction

    initial begin
        logic [kto_pkg::KEY_W-1:0] key;
        logic [31:0] stamp;
        logic [2:0] fn;
        int len, pick, b;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = kto_pkg::FN_FIND;
        send_gap_max = 16;
        i_rst_n = 0;
        for (int i = 0; i < POOL_N; i++) key_pool[i] = rand_key();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: empty table, extremes of length, match, prefix, ordinal, unassigned codes, remove.
        key = key_pool[0];
        send_cmd(kto_pkg::FN_COUNT, '0, 0, 0, 0);
        send_cmd(kto_pkg::FN_FIND, key, 32, 0, 0);
        send_cmd(kto_pkg::FN_NTH, '0, 0, 0, 0);
        send_cmd(kto_pkg::FN_CLEAR, '0, 0, 0, 0);
        send_cmd(kto_pkg::FN_UPSERT, key, 0, 32'h0, 0);
        send_cmd(kto_pkg::FN_UPSERT, key, 63, 32'hFFFF_FFFF, 255);
        send_cmd(kto_pkg::FN_UPSERT, '1, 32, 32'h1234_5678, 0);
        send_cmd(kto_pkg::FN_FIND, key, 32, 0, 0);
        send_cmd(kto_pkg::FN_FIND, key, 0, 0, 0);
        send_cmd(kto_pkg::FN_FIND, key, 33, 0, 0);
        send_cmd(kto_pkg::FN_FIND, key, 63, 0, 0);
        send_cmd(kto_pkg::FN_FIND, {~key[255:8], key[7:0]}, 1, 0, 0);
        send_cmd(kto_pkg::FN_FIND, '1, 32, 0, 0);
        send_cmd(kto_pkg::FN_NTH, '0, 0, 0, 1);
        send_cmd(kto_pkg::FN_NTH, '0, 0, 0, 2);
        send_cmd(kto_pkg::FN_NTH, '0, 0, 0, 255);
        send_cmd(kto_pkg::FN_CLEAR, '0, 0, 0, 0);
        send_cmd(kto_pkg::FN_SPARE6, key, 32, 0, 0);
        send_cmd(kto_pkg::FN_SPARE7, key, 32, 0, 0);
        send_cmd(kto_pkg::FN_REMOVE, key, 0, 0, 0);
        send_cmd(kto_pkg::FN_REMOVE, key, 16, 0, 0);
        send_cmd(kto_pkg::FN_REMOVE, key, 32, 0, 0);
        send_cmd(kto_pkg::FN_COUNT, '0, 0, 0, 0);

        // Fill every slot with the largest stamp so eviction falls on a tie.
        for (int i = 0; i < 33; i++)
            send_cmd(kto_pkg::FN_UPSERT, key_pool[i], 32, 32'hFFFF_FFFF, 0);
        send_cmd(kto_pkg::FN_NTH, '0, 0, 0, 31);
        send_cmd(kto_pkg::FN_NTH, '0, 0, 0, 32);

        // Random traffic over a key pool a bit larger than the table.
        for (int n = 0; n < 900; n++) begin
            if (n % 64 == 0) send_gap_max = $urandom_range(0, 2) == 0 ? 0 : 16;
            if (n == 450) wait (pending == 0);
            pick = $urandom_range(0, 99);
            if (pick < 35) fn = kto_pkg::FN_UPSERT;
            else if (pick < 57) fn = kto_pkg::FN_FIND;
            else if (pick < 75) fn = kto_pkg::FN_REMOVE;
            else if (pick < 86) fn = kto_pkg::FN_NTH;
            else if (pick < 91) fn = kto_pkg::FN_COUNT;
            else if (pick < 96) fn = kto_pkg::FN_CLEAR;
            else fn = $urandom_range(0, 1) == 0 ? kto_pkg::FN_SPARE6 : kto_pkg::FN_SPARE7;
            key = $urandom_range(0, 9) == 0 ? rand_key()
                                            : key_pool[$urandom_range(0, POOL_N - 1)];
            pick = $urandom_range(0, 9);
            len = pick == 0 ? $urandom_range(0, 63) : $urandom_range(1, 32);
            // Spoil a byte past the compared prefix so only a prefix matches.
            if ($urandom_range(0, 3) == 0 && len < 32 && len > 0) begin
                b = $urandom_range(len, 31);
                key[8*b +: 8] = key[8*b +: 8] ^ 8'($urandom_range(1, 255));
            end
            pick = $urandom_range(0, 9);
            stamp = pick == 0 ? 32'hFFFF_FFFF : pick < 4 ? $urandom_range(0, 7) : $urandom;
            send_cmd(fn, key, len, stamp,
                     $urandom_range(0, 7) == 0 ? $urandom_range(0, 255)
                                               : $urandom_range(0, 40));
        end

        wait (pending == 0);
        repeat (60) @(posedge i_clk);
        if (errors == 0)
            $display("[keyed_table_oldest_replace] OK");
        else
            $display("[keyed_table_oldest_replace] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
src/kto_pkg.sv
src/kto_cell.sv
src/kto_ctrl.sv
src/keyed_table_oldest_replace.sv
tb/kto_checker.sv
tb/tb_keyed_table_oldest_replace.sv
